// ----- rtl/lav_pkg.sv -----
package lav_pkg;

	// Width of the signed working vectors that are normalised.
	localparam int VW = 64;
	// Width of one Q1.14 axis component.
	localparam int QW = 16;
	// Depth of the queue between front and back.
	localparam int QDEPTH = 2;

	typedef logic signed [VW-1:0] vec_t;
	typedef logic signed [QW-1:0] axis_t;

	typedef enum logic [2:0] {
		N_IDLE,
		N_SCALE,
		N_SQUARE,
		N_ROOT,
		N_PREP,
		N_DIV,
		N_DONE
	} norm_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_NORM_Z,
		B_CROSS_X,
		B_NORM_X,
		B_CROSS_Y,
		B_NORM_Y,
		B_DOT,
		B_OUT
	} back_state_t;

	// Status of the word at the head of the queue.
	typedef struct packed {
		logic valid;
		logic look_zero;
	} item_flags_t;

	// Next and next-but-one index of a three component vector.
	function automatic logic [1:0] nxt1(input logic [1:0] i);
		case (i)
			2'd0: return 2'd1;
			2'd1: return 2'd2;
			default: return 2'd0;
		endcase
	endfunction

	function automatic logic [1:0] nxt2(input logic [1:0] i);
		case (i)
			2'd0: return 2'd2;
			2'd1: return 2'd0;
			default: return 2'd1;
		endcase
	endfunction

endpackage

// ----- rtl/lav_if.sv -----
interface lav_cam_if #(parameter int COORD_WIDTH = 32);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] pos_x;
	logic signed [COORD_WIDTH-1:0] pos_y;
	logic signed [COORD_WIDTH-1:0] pos_z;
	logic signed [COORD_WIDTH-1:0] look_x;
	logic signed [COORD_WIDTH-1:0] look_y;
	logic signed [COORD_WIDTH-1:0] look_z;
	logic signed [COORD_WIDTH-1:0] up_x;
	logic signed [COORD_WIDTH-1:0] up_y;
	logic signed [COORD_WIDTH-1:0] up_z;

	modport source (output valid, pos_x, pos_y, pos_z, look_x, look_y, look_z,
		up_x, up_y, up_z, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, look_x, look_y, look_z,
		up_x, up_y, up_z, output ready);
endinterface

interface lav_view_if #(parameter int COORD_WIDTH = 32);
	logic valid;
	logic ready;
	logic signed [15:0] right_x;
	logic signed [15:0] right_y;
	logic signed [15:0] right_z;
	logic signed [15:0] upward_x;
	logic signed [15:0] upward_y;
	logic signed [15:0] upward_z;
	logic signed [15:0] ahead_x;
	logic signed [15:0] ahead_y;
	logic signed [15:0] ahead_z;
	logic signed [COORD_WIDTH-1:0] shift_x;
	logic signed [COORD_WIDTH-1:0] shift_y;
	logic signed [COORD_WIDTH-1:0] shift_z;

	modport source (output valid, right_x, right_y, right_z, upward_x, upward_y,
		upward_z, ahead_x, ahead_y, ahead_z, shift_x, shift_y, shift_z, input ready);
	modport sink (input valid, right_x, right_y, right_z, upward_x, upward_y,
		upward_z, ahead_x, ahead_y, ahead_z, shift_x, shift_y, shift_z, output ready);
endinterface

// ----- rtl/look_at_view_matrix.sv -----
// Builds a right-handed look-at view basis from a camera position, a look direction and an
// up vector in signed Q16.16. A two-word queue takes camera words in at one per cycle while
// it has room and flags a zero look direction; the back end then normalises the three axes
// one after another on a single shared unit (range scaling, sum of squares, a
// one-bit-per-cycle square root and three one-bit-per-cycle dividers), with the cross and
// dot products on three registered multipliers. The time a normal word occupies the back
// end is set mainly by the 32-step square root and 15-step division of each of the three
// normalisations, plus their range scaling; a word whose up vector is zero or parallel to
// the look direction finishes sooner, and a word with a zero look direction goes straight
// to the output. The result register holds one finished word while the next is computed.
module look_at_view_matrix #(
	parameter int COORD_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	lav_cam_if.sink      cam,
	lav_view_if.source   view
);
	import lav_pkg::*;

	item_flags_t                   head;
	logic signed [COORD_WIDTH-1:0] head_pos [3];
	logic signed [COORD_WIDTH-1:0] head_look [3];
	logic signed [COORD_WIDTH-1:0] head_up [3];
	logic                          pop;

	lav_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cam       (cam),
		.pop       (pop),
		.head      (head),
		.head_pos  (head_pos),
		.head_look (head_look),
		.head_up   (head_up)
	);

	lav_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_pos  (head_pos),
		.head_look (head_look),
		.head_up   (head_up),
		.pop       (pop),
		.view      (view)
	);

`ifndef SYNTHESIS
	// The back end only takes a word that the queue holds.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid) else $error("pop from an empty queue");

	// A full queue always presents a word to the back end.
	a_full_head: assert property (@(posedge clk) disable iff (!arst_n)
		!cam.ready |-> head.valid) else $error("queue full but head not valid");

	// The back end never takes two words in a row.
	a_pop_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> !pop) else $error("back end took two words in a row");
`endif

endmodule

// ----- rtl/lav_front.sv -----
module lav_front #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	lav_cam_if.sink                       cam,
	input  logic                          pop,
	output lav_pkg::item_flags_t          head,
	output logic signed [COORD_WIDTH-1:0] head_pos [3],
	output logic signed [COORD_WIDTH-1:0] head_look [3],
	output logic signed [COORD_WIDTH-1:0] head_up [3]
);
	import lav_pkg::*;

	localparam int PTRW = $clog2(QDEPTH);

	logic signed [COORD_WIDTH-1:0] pos_q [QDEPTH][3];
	logic signed [COORD_WIDTH-1:0] look_q [QDEPTH][3];
	logic signed [COORD_WIDTH-1:0] up_q [QDEPTH][3];
	logic                          zero_q [QDEPTH];
	logic [PTRW-1:0]               wr_ptr_q;
	logic [PTRW-1:0]               rd_ptr_q;
	logic [PTRW:0]                 count_q;
	logic                          push;
	logic                          look_zero;

	assign cam.ready = (count_q != (PTRW+1)'(QDEPTH));
	assign push      = cam.valid && cam.ready;

	// Classify the word on entry: a zero look direction needs no arithmetic.
	assign look_zero = (cam.look_x == '0) && (cam.look_y == '0) && (cam.look_z == '0);

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			pos_q[wr_ptr_q]  <= '{cam.pos_x, cam.pos_y, cam.pos_z};
			look_q[wr_ptr_q] <= '{cam.look_x, cam.look_y, cam.look_z};
			up_q[wr_ptr_q]   <= '{cam.up_x, cam.up_y, cam.up_z};
			zero_q[wr_ptr_q] <= look_zero;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (PTRW+1)'(push) - (PTRW+1)'(pop);
		end
	end

	assign head.valid     = (count_q != '0);
	assign head.look_zero = zero_q[rd_ptr_q];
	assign head_pos       = pos_q[rd_ptr_q];
	assign head_look      = look_q[rd_ptr_q];
	assign head_up        = up_q[rd_ptr_q];

endmodule

// ----- rtl/lav_norm.sv -----
module lav_norm (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  lav_pkg::vec_t vin [3],
	output logic          done,
	output lav_pkg::axis_t vout [3]
);
	import lav_pkg::*;

	norm_state_t       st_q, st_d;
	logic [VW-1:0]     m_q [3];
	logic              sgn_q [3];
	logic [VW-1:0]     acc_q;
	logic [VW-1:0]     x_q;
	logic [VW-1:0]     r_q;
	logic [31:0]       n_q;
	logic [30:0]       rem_q [3];
	logic [14:0]       lo_q [3];
	logic [14:0]       quo_q [3];
	logic [4:0]        cnt_q;

	logic [VW-1:0]     mag [3];
	logic              all_zero;
	logic [VW-1:0]     ored;
	logic [59:0]       sq;
	logic [VW-1:0]     bitv;
	logic [VW-1:0]     trial;
	logic [31:0]       t [3];
	logic [44:0]       num [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = vin[i][VW-1] ? (VW'(0) - vin[i]) : vin[i];
			t[i]   = {rem_q[i], lo_q[i][14]};
			num[i] = {m_q[i][29:0], 14'b0} + 45'(r_q[31:1]);
		end
		all_zero = (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);
		// The OR of the magnitudes has the same leading one as their maximum.
		ored  = m_q[0] | m_q[1] | m_q[2];
		sq    = m_q[cnt_q[1:0]][29:0] * m_q[cnt_q[1:0]][29:0];
		bitv  = VW'(1) << {cnt_q, 1'b0};
		trial = r_q + bitv;
	end

	// Sequencer for scaling, sum of squares, square root and division.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= N_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		done = 1'b0;
		case (st_q)
			N_IDLE: begin
				if (go) begin
					st_d = all_zero ? N_DONE : N_SCALE;
				end
			end
			N_SCALE: begin
				if ((ored[VW-1:30] == '0) && ored[29]) begin
					st_d = N_SQUARE;
				end
			end
			N_SQUARE: begin
				if (cnt_q[1:0] == 2'd2) begin
					st_d = N_ROOT;
				end
			end
			N_ROOT: begin
				if (cnt_q == '0) begin
					st_d = N_PREP;
				end
			end
			N_PREP: begin
				st_d = N_DIV;
			end
			N_DIV: begin
				if (cnt_q == '0) begin
					st_d = N_DONE;
				end
			end
			N_DONE: begin
				done = 1'b1;
				st_d = N_IDLE;
			end
			default: begin
				st_d = N_IDLE;
			end
		endcase
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (st_q)
			N_IDLE: begin
				for (int i = 0; i < 3; i++) begin
					m_q[i]   <= mag[i];
					sgn_q[i] <= vin[i][VW-1];
					quo_q[i] <= '0;
				end
				acc_q <= '0;
				cnt_q <= '0;
			end
			N_SCALE: begin
				// Coarse steps of eight bits, then single bits.
				for (int i = 0; i < 3; i++) begin
					if (ored[VW-1:38] != '0) begin
						m_q[i] <= m_q[i] >> 8;
					end else if (ored[VW-1:30] != '0) begin
						m_q[i] <= m_q[i] >> 1;
					end else if (ored[29:22] == '0) begin
						m_q[i] <= m_q[i] << 8;
					end else if (!ored[29]) begin
						m_q[i] <= m_q[i] << 1;
					end
				end
			end
			N_SQUARE: begin
				acc_q <= acc_q + VW'(sq);
				if (cnt_q[1:0] == 2'd2) begin
					x_q   <= acc_q + VW'(sq);
					r_q   <= '0;
					cnt_q <= 5'd31;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			N_ROOT: begin
				// One result bit per cycle.
				if (x_q >= trial) begin
					x_q <= x_q - trial;
					r_q <= (r_q >> 1) + bitv;
				end else begin
					r_q <= r_q >> 1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
			N_PREP: begin
				n_q <= r_q[31:0];
				for (int i = 0; i < 3; i++) begin
					rem_q[i] <= 31'(num[i][44:15]);
					lo_q[i]  <= num[i][14:0];
				end
				cnt_q <= 5'd14;
			end
			N_DIV: begin
				// Three restoring dividers, one quotient bit per cycle each.
				for (int i = 0; i < 3; i++) begin
					if (t[i] >= n_q) begin
						rem_q[i] <= 31'(t[i] - n_q);
						quo_q[i] <= {quo_q[i][13:0], 1'b1};
					end else begin
						rem_q[i] <= t[i][30:0];
						quo_q[i] <= {quo_q[i][13:0], 1'b0};
					end
					lo_q[i] <= lo_q[i] << 1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vout[i] = sgn_q[i] ? (QW'(0) - QW'(quo_q[i])) : QW'(quo_q[i]);
		end
	end

endmodule

// ----- rtl/lav_back.sv -----
module lav_back #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lav_pkg::item_flags_t          head,
	input  logic signed [COORD_WIDTH-1:0] head_pos [3],
	input  logic signed [COORD_WIDTH-1:0] head_look [3],
	input  logic signed [COORD_WIDTH-1:0] head_up [3],
	output logic                          pop,
	lav_view_if.source                    view
);
	import lav_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int PW = COORD_WIDTH + QW;

	back_state_t          st_q, st_d;
	logic signed [W-1:0]  pos_q [3];
	logic signed [W-1:0]  look_q [3];
	logic signed [W-1:0]  up_q [3];
	axis_t                z_q [3];
	axis_t                x_q [3];
	axis_t                y_q [3];
	vec_t                 c_q [3];
	logic signed [W-1:0]  shift_q [3];
	logic [2:0]           step_q;
	logic                 norm_go_q;
	logic signed [PW-1:0] p_s1 [3];
	vec_t                 sum_s2;

	axis_t                o_axis_q [9];
	logic signed [W-1:0]  o_shift_q [3];
	logic                 vld_q;

	logic signed [W-1:0]  mul_a [3];
	axis_t                mul_b [3];
	vec_t                 norm_in [3];
	logic                 norm_done;
	axis_t                norm_out [3];
	logic [1:0]           s;
	logic [1:0]           i1, i2;
	logic signed [PW:0]   diff;
	logic                 out_free;
	logic                 s_neg;
	logic [VW-1:0]        mag;
	logic [VW-1:0]        rnd;
	logic [VW-1:0]        lim;
	logic [VW-1:0]        sat;

	assign s        = step_q[1:0];
	assign i1       = nxt1(s);
	assign i2       = nxt2(s);
	assign out_free = !vld_q || view.ready;
	assign pop      = (st_q == B_IDLE) && head.valid;

	// Shared normalising unit.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			norm_in[i] = (st_q == B_NORM_Z) ? (VW'(0) - VW'(look_q[i])) : c_q[i];
		end
	end

	lav_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (norm_go_q),
		.vin    (norm_in),
		.done   (norm_done),
		.vout   (norm_out)
	);

	// Multiplier operands for cross products and dot products.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mul_a[k] = pos_q[k];
			mul_b[k] = z_q[k];
		end
		case (st_q)
			B_CROSS_X: begin
				mul_a[0] = up_q[i1];
				mul_b[0] = z_q[i2];
				mul_a[1] = up_q[i2];
				mul_b[1] = z_q[i1];
			end
			B_CROSS_Y: begin
				mul_a[0] = W'(z_q[i1]);
				mul_b[0] = x_q[i2];
				mul_a[1] = W'(z_q[i2]);
				mul_b[1] = x_q[i1];
			end
			B_DOT: begin
				for (int k = 0; k < 3; k++) begin
					case (s)
						2'd0: mul_b[k] = x_q[k];
						2'd1: mul_b[k] = y_q[k];
						default: mul_b[k] = z_q[k];
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	// Cross component difference and translation rounding with saturation.
	always_comb begin
		diff  = (PW+1)'(p_s1[0]) - (PW+1)'(p_s1[1]);
		s_neg = (sum_s2 > 0);
		mag   = sum_s2[VW-1] ? (VW'(0) - sum_s2) : sum_s2;
		rnd   = (mag + (VW'(1) << 13)) >> 14;
		lim   = VW'(1) << (W-1);
		if (s_neg) begin
			sat = (rnd > lim) ? lim : (VW'(0) - rnd);
		end else begin
			sat = (rnd > lim - 1'b1) ? (lim - 1'b1) : rnd;
		end
	end

	// Back sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= B_IDLE;
			norm_go_q <= 1'b0;
			vld_q     <= 1'b0;
		end else begin
			st_q      <= st_d;
			norm_go_q <= (pop && !head.look_zero) ||
				((st_q == B_CROSS_X || st_q == B_CROSS_Y) && step_q == 3'd3);
			if (st_q == B_OUT && out_free) begin
				vld_q <= 1'b1;
			end else if (view.ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			B_IDLE: begin
				if (head.valid) begin
					st_d = head.look_zero ? B_OUT : B_NORM_Z;
				end
			end
			B_NORM_Z: begin
				if (norm_done) begin
					st_d = B_CROSS_X;
				end
			end
			B_CROSS_X: begin
				if (step_q == 3'd3) begin
					st_d = B_NORM_X;
				end
			end
			B_NORM_X: begin
				if (norm_done) begin
					st_d = B_CROSS_Y;
				end
			end
			B_CROSS_Y: begin
				if (step_q == 3'd3) begin
					st_d = B_NORM_Y;
				end
			end
			B_NORM_Y: begin
				if (norm_done) begin
					st_d = B_DOT;
				end
			end
			B_DOT: begin
				if (step_q == 3'd4) begin
					st_d = B_OUT;
				end
			end
			B_OUT: begin
				if (out_free) begin
					st_d = B_IDLE;
				end
			end
			default: begin
				st_d = B_IDLE;
			end
		endcase
	end

	// Working registers of the back end.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			p_s1[k] <= mul_a[k] * mul_b[k];
		end
		sum_s2 <= VW'(p_s1[0]) + VW'(p_s1[1]) + VW'(p_s1[2]);
		// The step count restarts while a normalisation runs.
		if (st_q inside {B_NORM_Z, B_NORM_X, B_NORM_Y}) begin
			step_q <= '0;
		end else begin
			step_q <= step_q + 1'b1;
		end
		case (st_q)
			B_IDLE: begin
				pos_q  <= head_pos;
				look_q <= head_look;
				up_q   <= head_up;
				for (int k = 0; k < 3; k++) begin
					x_q[k]     <= '0;
					y_q[k]     <= '0;
					z_q[k]     <= '0;
					shift_q[k] <= '0;
				end
			end
			B_NORM_Z: begin
				if (norm_done) begin
					z_q <= norm_out;
				end
			end
			B_NORM_X: begin
				if (norm_done) begin
					x_q <= norm_out;
				end
			end
			B_NORM_Y: begin
				if (norm_done) begin
					y_q <= norm_out;
				end
			end
			B_CROSS_X, B_CROSS_Y: begin
				if (step_q != 3'd0) begin
					c_q[2'(step_q - 1'b1)] <= VW'(diff);
				end
			end
			B_DOT: begin
				if (step_q >= 3'd2) begin
					shift_q[2'(step_q - 3'd2)] <= sat[W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (st_q == B_OUT && out_free) begin
			o_axis_q  <= '{x_q[0], x_q[1], x_q[2], y_q[0], y_q[1], y_q[2],
				z_q[0], z_q[1], z_q[2]};
			o_shift_q <= shift_q;
		end
	end

	assign view.valid    = vld_q;
	assign view.right_x  = o_axis_q[0];
	assign view.right_y  = o_axis_q[1];
	assign view.right_z  = o_axis_q[2];
	assign view.upward_x = o_axis_q[3];
	assign view.upward_y = o_axis_q[4];
	assign view.upward_z = o_axis_q[5];
	assign view.ahead_x  = o_axis_q[6];
	assign view.ahead_y  = o_axis_q[7];
	assign view.ahead_z  = o_axis_q[8];
	assign view.shift_x  = o_shift_q[0];
	assign view.shift_y  = o_shift_q[1];
	assign view.shift_z  = o_shift_q[2];

endmodule

// ----- test/lav_checker.sv -----
module lav_checker #(
	parameter int COORD_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	lav_cam_if.sink     cam,
	lav_view_if.sink    view,
	output int          fail_count,
	output int          pending
);

	typedef logic signed [15:0] q14_t;
	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	// One expected view word.
	typedef struct {
		q14_t   axis[9];
		coord_t shift[3];
	} basis_t;

	basis_t expected_views[$];

	// Integer square root of a 64-bit value, one bit pair at a time.
	function automatic logic [63:0] root64(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] mag(input longint v);
		return v < 0 ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	// Scale the vector so its largest magnitude has 30 bits, then divide by the length.
	function automatic void unit_vec(input longint v[3], output longint o[3]);
		logic [63:0] m[3];
		logic [63:0] mx;
		logic [63:0] t;
		logic [63:0] sq;
		logic [63:0] n;
		logic [63:0] q;
		int nbits;
		mx = 0;
		nbits = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = mag(v[i]);
			if (m[i] > mx)
				mx = m[i];
		end
		if (mx == 0) begin
			for (int i = 0; i < 3; i++)
				o[i] = 0;
			return;
		end
		for (t = mx; t != 0; t = t >> 1)
			nbits++;
		for (int i = 0; i < 3; i++)
			m[i] = nbits > 30 ? m[i] >> (nbits - 30) : m[i] << (30 - nbits);
		sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		n = root64(sq);
		for (int i = 0; i < 3; i++) begin
			q = (m[i] * 64'd16384 + n / 2) / n;
			o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
	endfunction

	// Negated dot product, rounded from Q17.30 to Q16.16 and saturated.
	function automatic coord_t translation(input longint a[3], input longint p[3]);
		longint s;
		logic [63:0] r;
		logic [63:0] lim_pos;
		logic [63:0] lim_neg;
		s = -(a[0] * p[0] + a[1] * p[1] + a[2] * p[2]);
		r = (mag(s) + 64'd8192) >> 14;
		lim_pos = (64'd1 << (COORD_WIDTH - 1)) - 1;
		lim_neg = 64'd1 << (COORD_WIDTH - 1);
		if (s < 0)
			return r > lim_neg ? coord_t'(-longint'(lim_neg)) : coord_t'(-longint'(r));
		return r > lim_pos ? coord_t'(lim_pos) : coord_t'(r);
	endfunction

	function automatic basis_t view_basis(input longint pos[3], input longint look[3],
			input longint up[3]);
		basis_t b;
		longint nz[3];
		longint z[3];
		longint cx[3];
		longint x[3];
		longint cy[3];
		longint y[3];
		for (int i = 0; i < 3; i++)
			nz[i] = -look[i];
		unit_vec(nz, z);
		cx[0] = up[1] * z[2] - up[2] * z[1];
		cx[1] = up[2] * z[0] - up[0] * z[2];
		cx[2] = up[0] * z[1] - up[1] * z[0];
		unit_vec(cx, x);
		cy[0] = z[1] * x[2] - z[2] * x[1];
		cy[1] = z[2] * x[0] - z[0] * x[2];
		cy[2] = z[0] * x[1] - z[1] * x[0];
		unit_vec(cy, y);
		for (int i = 0; i < 3; i++) begin
			b.axis[i] = q14_t'(x[i]);
			b.axis[3 + i] = q14_t'(y[i]);
			b.axis[6 + i] = q14_t'(z[i]);
		end
		b.shift[0] = translation(x, pos);
		b.shift[1] = translation(y, pos);
		b.shift[2] = translation(z, pos);
		return b;
	endfunction

	assign pending = expected_views.size();

	// Predict on each accepted camera word and compare each accepted view word.
	always @(posedge clk) begin
		longint p[3];
		longint l[3];
		longint u[3];
		basis_t want;
		q14_t got_axis[9];
		coord_t got_shift[3];
		if (arst_n && cam.valid && cam.ready) begin
			p = '{longint'(cam.pos_x), longint'(cam.pos_y), longint'(cam.pos_z)};
			l = '{longint'(cam.look_x), longint'(cam.look_y), longint'(cam.look_z)};
			u = '{longint'(cam.up_x), longint'(cam.up_y), longint'(cam.up_z)};
			expected_views.push_back(view_basis(p, l, u));
		end
		if (arst_n && view.valid && view.ready) begin
			got_axis = '{view.right_x, view.right_y, view.right_z, view.upward_x,
				view.upward_y, view.upward_z, view.ahead_x, view.ahead_y, view.ahead_z};
			got_shift = '{view.shift_x, view.shift_y, view.shift_z};
			if (expected_views.size() == 0) begin
				$display("%0t: view word with none expected", $time);
				fail_count++;
			end else begin
				want = expected_views.pop_front();
				for (int i = 0; i < 9; i++)
					if (got_axis[i] !== want.axis[i]) begin
						$display("%0t: axis %0d expected %0d got %0d", $time, i,
							want.axis[i], got_axis[i]);
						fail_count++;
					end
				for (int i = 0; i < 3; i++)
					if (got_shift[i] !== want.shift[i]) begin
						$display("%0t: shift %0d expected %0d got %0d", $time, i,
							want.shift[i], got_shift[i]);
						fail_count++;
					end
			end
		end
	end

	initial fail_count = 0;

endmodule

// ----- test/tb_top.sv -----
module tb_top;

	localparam int CW = 32;
	localparam int DIRECTED = 16;
	localparam int RANDOM_ITEMS = 550;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	int fail_count;
	int pending;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_off;
	longint cycles;

	lav_cam_if #(.COORD_WIDTH(CW)) cam ();
	lav_view_if #(.COORD_WIDTH(CW)) view ();

	look_at_view_matrix #(.COORD_WIDTH(CW)) dut (
		.clk(clk), .arst_n(arst_n), .cam(cam.sink), .view(view.source)
	);

	lav_checker #(.COORD_WIDTH(CW)) checker_i (
		.clk(clk), .arst_n(arst_n), .cam(cam.sink), .view(view.sink),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Timeout watchdog.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// The receiver stalls at random, or for a long stretch while hold_off is set.
	initial begin
		view.ready = 0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				view.ready <= 0;
				for (int i = 0; i < 1500; i++)
					@(negedge clk);
				hold_off = 0;
			end
			view.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic logic [CW-1:0] rnd_coord();
		case ($urandom_range(5))
			0: return $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
			1: return CW'($signed($urandom_range(262144)) - 131072);
			2: return 0;
			default: return CW'($urandom);
		endcase
	endfunction

	// Offer one camera word and wait for it to be taken. Ready only changes at the
	// rising edge, so its value at the falling edge tells whether the next edge accepts.
	task automatic send_camera(input logic [CW-1:0] f[9]);
		while ($urandom_range(99) < send_idle_pct) begin
			cam.valid <= 0;
			@(negedge clk);
		end
		{cam.pos_x, cam.pos_y, cam.pos_z} <= {f[0], f[1], f[2]};
		{cam.look_x, cam.look_y, cam.look_z} <= {f[3], f[4], f[5]};
		{cam.up_x, cam.up_y, cam.up_z} <= {f[6], f[7], f[8]};
		cam.valid <= 1;
		while (!cam.ready)
			@(negedge clk);
		@(negedge clk);
	endtask

	initial begin
		logic [CW-1:0] f[9];
		logic [CW-1:0] mx;
		logic [CW-1:0] mn;
		logic [CW-1:0] one;
		mx = {1'b0, {(CW-1){1'b1}}};
		mn = {1'b1, {(CW-1){1'b0}}};
		one = CW'(65536);
		hold_off = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 0;
		cam.valid = 0;
		{cam.pos_x, cam.pos_y, cam.pos_z} = '0;
		{cam.look_x, cam.look_y, cam.look_z} = '0;
		{cam.up_x, cam.up_y, cam.up_z} = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed words: standard camera, zero look, zero up, up parallel to look,
		// extremes of position for saturation, and all-ones/all-zeros fields.
		f = '{0, 0, 0, 0, 0, one, 0, one, 0};
		send_camera(f);
		f = '{one, one, one, 0, 0, 0, 0, one, 0};
		send_camera(f);
		f = '{one, 0, 0, one, 0, 0, 0, 0, 0};
		send_camera(f);
		f = '{one, one, 0, 0, one, 0, 0, one, 0};
		send_camera(f);
		f = '{mx, mx, mx, one, one, one, 0, one, 0};
		send_camera(f);
		f = '{mn, mn, mn, one, one, one, 0, one, 0};
		send_camera(f);
		f = '{mx, mn, mx, mn, mx, mn, mx, mn, mx};
		send_camera(f);
		f = '{mn, mx, mn, mx, mn, mx, mn, mx, mn};
		send_camera(f);
		f = '{mx, mx, mx, mn, mn, mn, mn, mx, 0};
		send_camera(f);
		f = '{1, -1, 1, 1, 0, 0, 0, 1, 0};
		send_camera(f);
		f = '{mn, mn, mn, 0, 0, -1, 0, -one, mn};
		send_camera(f);
		f = '{'1, '1, '1, '1, '1, '1, '1, '1, '1};
		send_camera(f);
		f = '{-one, one, -one, 0, 0, -one, 0, one, 0};
		send_camera(f);
		f = '{mx, 0, 0, 0, mn, 0, mn, 0, 0};
		send_camera(f);
		f = '{0, mx, 0, mx, 0, 0, 0, 0, mx};
		send_camera(f);
		f = '{0, 0, mx, 0, one, 0, 0, mn, 0};
		send_camera(f);

		// Random words in three idling phases; a long receiver hold-off in the first.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 0) begin
				send_idle_pct = 24;
				recv_idle_pct = 47;
			end else if (i == RANDOM_ITEMS / 3) begin
				send_idle_pct = 47;
				recv_idle_pct = 24;
			end else if (i == 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (i == 20)
				hold_off = 1;
			for (int k = 0; k < 9; k++)
				f[k] = rnd_coord();
			// Now and then make up parallel to look.
			if ($urandom_range(15) == 0)
				{f[6], f[7], f[8]} = {f[3], f[4], f[5]};
			send_camera(f);
		end
		cam.valid <= 0;

		while (pending != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/lav_pkg.sv
rtl/lav_if.sv
rtl/lav_front.sv
rtl/lav_norm.sv
rtl/lav_back.sv
rtl/look_at_view_matrix.sv
test/lav_checker.sv
test/tb_top.sv
